// ----- src/fp64_matrix_multiply_engine_defines.svh -----
// ---------------------------------------------------------------------------
// fpmm assertion macros
// Shared concurrent assertion forms for the matrix multiply engine checker.
// ---------------------------------------------------------------------------
`ifndef FP64_MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define FP64_MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FPMM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpmm: assertion failed");

// next-cycle implication
`define FPMM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpmm: assertion failed");

`endif

// ----- src/fpmm_pkg.sv -----
// ---------------------------------------------------------------------------
// fpmm_pkg
// Types and constants of the binary64 matrix multiply engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpmm_pkg;

    localparam int MAX_COLS  = 16;
    localparam int MAX_DEPTH = 512;
    localparam int MAX_ROWS  = 1024;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int DEPTH_W = $clog2(MAX_DEPTH);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ADDR_W  = DEPTH_W + COL_W;

    // configuration register widths
    localparam int ROWCNT_W   = 11;
    localparam int INNER_W    = 10;
    localparam int COLCNT_W   = 5;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd2;

    localparam logic OP_LOAD_B = 1'b0;
    localparam logic OP_MAC    = 1'b1;

    localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] F64_INF  = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic               opcode;
        logic [ROW_W-1:0]   row_index;
        logic [DEPTH_W-1:0] depth_index;
        logic [COL_W-1:0]   col_index;
        logic [63:0]        element_value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic [63:0]      out_value;
        logic             last_of_row;
        logic             last_of_matrix;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_MUL,
        S_NORM,
        S_ALIGN,
        S_ADD,
        S_NEG,
        S_RSHIFT,
        S_ROUND,
        S_WB,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        NRM_P,
        NRM_Q,
        NRM_S
    } t_nsel;

endpackage

`default_nettype wire

// ----- src/fp64_matrix_multiply_engine.sv -----
// ---------------------------------------------------------------------------
// fp64_matrix_multiply_engine
// C = A x B in IEEE binary64 with one shared fused multiply-add datapath.
// ---------------------------------------------------------------------------
// Load B first (opcode 0, stored by depth and column), then stream A
// row-major (opcode 1). Each A item runs a fused multiply-add with
// round-to-nearest-even on every column accumulator, one column after the
// other through a single sequenced FMA datapath; o_in_stall stays high until
// the sweep is done. Per column: a RAM read, stepwise 53x14 partial
// products and product normalization (16 bits or one bit per step). A zero
// accumulator then goes straight to rounding. Otherwise addend
// normalization, align, add, an optional negate and result normalization
// follow. Rounding is a right shift and a round step, which overflow skips,
// and write-back ends the column. A NaN, infinity or zero operand goes from
// the operand load straight to write-back. The A item at the last depth
// then emits one item per column, one per cycle when not stalled, and the
// input stays stalled until the last of them sits in the output register.
// B items and out-of-range items are taken back to back.
// Reading a B entry that was never loaded gives an unspecified value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fp64_matrix_multiply_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // A / B element items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire fpmm_pkg::t_in_item                i_in_item,
    // C element items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output fpmm_pkg::t_out_item                    o_out_item,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [fpmm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fpmm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import fpmm_pkg::*;

    // 128-bit right shift; bits shifted out are ORed into bit 0
    function automatic logic [127:0] shr_jam(input logic [127:0] x, input logic [13:0] n);
        logic [127:0] sh;
        logic         lost;
        if (n >= 14'd128) begin
            shr_jam = {127'b0, |x};
        end else begin
            sh      = x >> n[6:0];
            lost    = (sh << n[6:0]) != x;
            shr_jam = sh | {127'b0, lost};
        end
    endfunction

    // ---------------- configuration ----------------
    logic [ROWCNT_W-1:0] r_row_count;
    logic [INNER_W-1:0]  r_inner_count;
    logic [COLCNT_W-1:0] r_num_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= ROWCNT_W'(1);
            r_inner_count <= INNER_W'(1);
            r_num_cols    <= COLCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[ROWCNT_W-1:0];
                CFG_INNER_COUNT: r_inner_count <= i_cfg_data[INNER_W-1:0];
                CFG_COL_COUNT:   r_num_cols    <= i_cfg_data[COLCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // oversized column and inner counts clamp to the storage
    logic [COLCNT_W-1:0] cols_eff;
    logic [INNER_W-1:0]  inner_eff;
    assign cols_eff  = (r_num_cols > COLCNT_W'(MAX_COLS)) ? COLCNT_W'(MAX_COLS) : r_num_cols;
    assign inner_eff = (r_inner_count > INNER_W'(MAX_DEPTH)) ? INNER_W'(MAX_DEPTH)
                                                             : r_inner_count;

    // ---------------- state ----------------
    t_state r_state, n_state;
    t_nsel  r_nsel;

    logic [63:0]        r_acc [MAX_COLS];
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_emit;
    logic [63:0]        r_a;
    logic [63:0]        r_c;
    logic               r_cz;
    logic               r_sp;
    logic               r_sr;
    logic [52:0]        r_ma;
    logic [55:0]        r_mb;
    logic [1:0]         r_mcnt;
    logic [127:0]       r_x, r_p, r_q;
    logic signed [13:0] r_ex, r_ep, r_eq;
    logic [10:0]        r_bias;
    logic [63:0]        r_res;

    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- input decode ----------------
    // a_hit: A item in range (clears on depth 0 even with no columns)
    // a_ok:  A item that also needs a column sweep
    logic in_acc, b_ok, a_hit, a_ok;
    assign in_acc = i_in_valid && (r_state == S_IDLE);
    assign b_ok   = ({1'b0, i_in_item.depth_index} < inner_eff)
                 && ({1'b0, i_in_item.col_index} < cols_eff);
    assign a_hit  = ({1'b0, i_in_item.row_index} < r_row_count)
                 && ({1'b0, i_in_item.depth_index} < inner_eff);
    assign a_ok   = a_hit && (cols_eff != '0);

    // ---------------- B store ----------------
    logic [63:0] b_rdata;

    fpmm_ram #(
        .WIDTH (64),
        .DEPTH (MAX_DEPTH * MAX_COLS)
    ) u_bram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_in_item.opcode == OP_LOAD_B) && b_ok),
        .i_waddr ({i_in_item.depth_index, i_in_item.col_index}),
        .i_wdata (i_in_item.element_value),
        .i_raddr ({r_depth, r_col}),
        .o_rdata (b_rdata)
    );

    // ---------------- operand unpack / special cases ----------------
    logic [63:0] c_val;
    logic [10:0] ea, eb, ec, ea1, eb1;
    logic        sa, sb, sc, sp;
    logic        az, bz, cz, a_nan, b_nan, c_nan;
    logic        spec;
    logic [63:0] spec_res;

    assign c_val = r_acc[r_col];
    assign ea = r_a[62:52];
    assign eb = b_rdata[62:52];
    assign ec = c_val[62:52];
    assign sa = r_a[63];
    assign sb = b_rdata[63];
    assign sc = c_val[63];
    assign sp = sa ^ sb;
    assign az = (r_a[62:0] == '0);
    assign bz = (b_rdata[62:0] == '0);
    assign cz = (c_val[62:0] == '0);
    assign a_nan = (ea == 11'h7FF) && (r_a[51:0] != '0);
    assign b_nan = (eb == 11'h7FF) && (b_rdata[51:0] != '0);
    assign c_nan = (ec == 11'h7FF) && (c_val[51:0] != '0);
    assign ea1 = (ea == '0) ? 11'd1 : ea;
    assign eb1 = (eb == '0) ? 11'd1 : eb;

    always_comb begin
        spec     = 1'b1;
        spec_res = c_val;
        if (a_nan || b_nan || c_nan) begin
            spec_res = F64_QNAN;
        end else if (ea == 11'h7FF || eb == 11'h7FF) begin
            if (az || bz)                        spec_res = F64_QNAN;
            else if (ec == 11'h7FF && sc != sp)  spec_res = F64_QNAN;
            else                                 spec_res = {sp, F64_INF[62:0]};
        end else if (ec == 11'h7FF) begin
            spec_res = c_val;
        end else if (az || bz) begin
            spec_res = cz ? {sp & sc, 63'b0} : c_val;
        end else begin
            spec = 1'b0;
        end
    end

    // addend mantissa and exponent, from the latched accumulator value
    logic [52:0]        mc;
    logic signed [13:0] ec0;
    assign mc  = (r_c[62:52] == '0) ? {1'b0, r_c[51:0]} : {1'b1, r_c[51:0]};
    assign ec0 = $signed({3'b0, ((r_c[62:52] == '0) ? 11'd1 : r_c[62:52])}) - 14'sd1075;

    // ---------------- shared datapath pieces ----------------
    logic [66:0] pp;
    assign pp = r_ma * r_mb[55:42];

    // normalizer: target leading one at bit 125
    logic [127:0]       norm_x;
    logic signed [13:0] norm_e;
    logic               norm_done;
    always_comb begin
        norm_x    = r_x;
        norm_e    = r_ex;
        norm_done = 1'b1;
        if (r_x[126]) begin
            norm_x = {1'b0, r_x[127:1]} | {127'b0, r_x[0]};
            norm_e = r_ex + 14'sd1;
        end else if (!r_x[125]) begin
            norm_done = 1'b0;
            if (r_x[125:110] == '0) begin
                norm_x = r_x << 16;
                norm_e = r_ex - 14'sd16;
            end else begin
                norm_x = r_x << 1;
                norm_e = r_ex - 14'sd1;
            end
        end
    end

    logic signed [13:0] dexp;
    logic [127:0]       sum;
    logic [128:0]       diff;
    assign dexp = r_ep - r_eq;
    assign sum  = r_p + r_q;
    assign diff = {1'b0, r_p} - {1'b0, r_q};

    logic signed [13:0] biased;
    logic               ovf, tiny;
    assign biased = r_ex + 14'sd1148;
    assign ovf    = (biased >= 14'sd2047);
    assign tiny   = (biased < 14'sd1);

    logic        rnd_inc;
    logic [63:0] rnd_r;
    assign rnd_inc = r_x[1] & (r_x[0] | r_x[2]);
    assign rnd_r   = {1'b0, r_bias - 11'd1, 52'b0} + {2'b0, r_x[63:2]} + {63'b0, rnd_inc};

    logic col_last;
    logic [COLCNT_W-1:0] cols_m1;
    assign cols_m1  = cols_eff - COLCNT_W'(1);
    assign col_last = (r_col == cols_m1[COL_W-1:0]);

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_item.opcode == OP_MAC && a_ok) n_state = S_RD;
            end
            S_RD:     n_state = S_LOAD;
            S_LOAD:   n_state = spec ? S_WB : S_MUL;
            S_MUL:    if (r_mcnt == 2'd3) n_state = S_NORM;
            S_NORM: begin
                if (r_nsel == NRM_S && r_x == '0) begin
                    n_state = S_WB;
                end else if (norm_done) begin
                    unique case (r_nsel)
                        NRM_P:   n_state = r_cz ? S_RSHIFT : S_NORM;
                        NRM_Q:   n_state = S_ALIGN;
                        default: n_state = S_RSHIFT;
                    endcase
                end
            end
            S_ALIGN:  n_state = S_ADD;
            S_ADD:    n_state = (r_sp != r_c[63] && diff[128]) ? S_NEG : S_NORM;
            S_NEG:    n_state = S_NORM;
            S_RSHIFT: n_state = ovf ? S_WB : S_ROUND;
            S_ROUND:  n_state = S_WB;
            S_WB: begin
                if (!col_last)   n_state = S_RD;
                else if (r_emit) n_state = S_EMIT;
                else             n_state = S_IDLE;
            end
            S_EMIT:   if (out_free && col_last) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // accumulators: reset and depth-0 clear to +0.0, column result on write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_COLS; j++) r_acc[j] <= '0;
        end else if (in_acc && i_in_item.opcode == OP_MAC && a_hit
                     && i_in_item.depth_index == '0) begin
            for (int j = 0; j < MAX_COLS; j++) r_acc[j] <= '0;
        end else if (r_state == S_WB) begin
            r_acc[r_col] <= r_res;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col   <= '0;
                r_row   <= i_in_item.row_index;
                r_depth <= i_in_item.depth_index;
                r_a     <= i_in_item.element_value;
                r_emit  <= ({1'b0, i_in_item.depth_index} + INNER_W'(1)) == inner_eff;
            end
            S_LOAD: begin
                r_res  <= spec_res;
                r_c    <= c_val;
                r_cz   <= cz;
                r_sp   <= sp;
                r_sr   <= sp;
                r_ma   <= {(ea != '0), r_a[51:0]};
                r_mb   <= {3'b0, (eb != '0), b_rdata[51:0]};
                r_mcnt <= '0;
                r_x    <= '0;
                r_ex   <= $signed({3'b0, ea1}) + $signed({3'b0, eb1}) - 14'sd2150;
                r_nsel <= NRM_P;
            end
            S_MUL: begin
                r_x    <= (r_x << 14) + {61'b0, pp};
                r_mb   <= r_mb << 14;
                r_mcnt <= r_mcnt + 2'd1;
            end
            S_NORM: begin
                if (r_nsel == NRM_S && r_x == '0) begin
                    r_res <= '0;
                end else if (norm_done) begin
                    unique case (r_nsel)
                        NRM_P: begin
                            r_p  <= norm_x;
                            r_ep <= norm_e;
                            if (!r_cz) begin
                                // product done, addend goes through next
                                r_x    <= {75'b0, mc};
                                r_ex   <= ec0;
                                r_nsel <= NRM_Q;
                            end else begin
                                r_x  <= norm_x;
                                r_ex <= norm_e;
                            end
                        end
                        NRM_Q: begin
                            r_q  <= norm_x;
                            r_eq <= norm_e;
                        end
                        default: begin
                            r_x  <= norm_x;
                            r_ex <= norm_e;
                        end
                    endcase
                end else begin
                    r_x  <= norm_x;
                    r_ex <= norm_e;
                end
            end
            S_ALIGN: begin
                if (!dexp[13]) begin
                    r_q  <= shr_jam(r_q, dexp);
                    r_ex <= r_ep;
                end else begin
                    r_p  <= shr_jam(r_p, -dexp);
                    r_ex <= r_eq;
                end
            end
            S_ADD: begin
                r_nsel <= NRM_S;
                if (r_sp == r_c[63]) begin
                    r_x  <= sum;
                    r_sr <= r_sp;
                end else begin
                    r_x  <= diff[127:0];
                    r_sr <= diff[128] ? r_c[63] : r_sp;
                end
            end
            S_NEG: r_x <= 128'd0 - r_x;
            S_RSHIFT: begin
                r_res  <= {r_sr, F64_INF[62:0]};
                r_bias <= tiny ? 11'd1 : biased[10:0];
                r_x    <= shr_jam(r_x, tiny ? (14'sd72 - biased) : 14'd71);
            end
            S_ROUND: begin
                r_res <= {r_sr, (rnd_r >= F64_INF) ? F64_INF[62:0] : rnd_r[62:0]};
            end
            S_WB:   if (!col_last) r_col <= r_col + COL_W'(1);
                    else           r_col <= '0;
            S_EMIT: if (out_free)  r_col <= r_col + COL_W'(1);
            default: ;
        endcase
    end

    // output register: one C item per column of the finished row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_item.out_row        <= r_row;
            r_out_item.out_col        <= r_col;
            r_out_item.out_value      <= c_val;
            r_out_item.last_of_row    <= col_last;
            r_out_item.last_of_matrix <= col_last
                && (({1'b0, r_row} + ROWCNT_W'(1)) == r_row_count);
        end
    end

endmodule

`default_nettype wire

// ----- src/fpmm_ram.sv -----
// ---------------------------------------------------------------------------
// fpmm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpmm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/fpmm_checker.sv -----
// ---------------------------------------------------------------------------
// fpmm_checker
// Port-level assertions for the matrix multiply engine, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fp64_matrix_multiply_engine_defines.svh"

module fpmm_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire fpmm_pkg::t_out_item o_out_item
);

    import fpmm_pkg::*;

    // stalled output item holds
    `FPMM_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    // end of matrix is always the end of a row
    `FPMM_ASSERT_IMP(a_last_mat, o_out_valid && o_out_item.last_of_matrix, o_out_item.last_of_row)
    // while a row is still being emitted no new item is taken
    `FPMM_ASSERT_IMP(a_busy_row, o_out_valid && !o_out_item.last_of_row, o_in_stall)

endmodule

bind fp64_matrix_multiply_engine fpmm_checker u_fpmm_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_fp64_matrix_multiply_engine.sv -----
// ---------------------------------------------------------------------------
// tb_fp64_matrix_multiply_engine
// Self-checking bench for the binary64 matrix multiply engine.
// ---------------------------------------------------------------------------
// B items are loaded first, then A items stream through in row-major order.
// A scoreboard class keeps its own copy of the B matrix, the column
// accumulators and the dimension registers. It predicts each C item with a
// bit-exact fused multiply-add and compares every C item, field by field,
// in order. Both channels idle and stall at random, with calm stretches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_fp64_matrix_multiply_engine;
    import fpmm_pkg::*;

    localparam logic [63:0] F64_SIGN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] F64_FRAC   = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] F64_HIDDEN = 64'h0010_0000_0000_0000;
    localparam int          SETTLE_CYC = 1600;  // above the slowest 16-column sweep

    // -----------------------------------------------------------------------
    // Bit-exact binary64 fused multiply-add, one rounding to nearest even
    // -----------------------------------------------------------------------
    function automatic int top_bit(input logic [127:0] x);
        for (int i = 127; i >= 0; i--)
            if (x[i]) return i;
        return -1;
    endfunction

    // right shift; anything shifted out sets bit 0
    function automatic logic [127:0] shr_sticky(input logic [127:0] x, input int n);
        logic [127:0] r;
        if (n <= 0) return x;
        if (n >= 128) return {127'b0, |x};
        r = x >> n;
        r[0] = r[0] | ((x << (128 - n)) != 0);
        return r;
    endfunction

    function automatic logic [63:0] fused_mac(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c);
        int ea, eb, ec, e, ep, k, biased, shift;
        logic sa, sb, sc, sp, sr, az, bz, cz;
        logic [127:0] p, q, s, t;
        logic [63:0] frac, r;
        ea = int'(a[62:52]); eb = int'(b[62:52]); ec = int'(c[62:52]);
        sa = a[63]; sb = b[63]; sc = c[63]; sp = sa ^ sb;
        az = (a & ~F64_SIGN) == 0; bz = (b & ~F64_SIGN) == 0; cz = (c & ~F64_SIGN) == 0;
        if ((ea == 2047 && (a & F64_FRAC) != 0) || (eb == 2047 && (b & F64_FRAC) != 0) ||
            (ec == 2047 && (c & F64_FRAC) != 0))
            return F64_QNAN;
        if (ea == 2047 || eb == 2047) begin
            if (az || bz) return F64_QNAN;
            if (ec == 2047 && sc != sp) return F64_QNAN;
            return {sp, 63'b0} | F64_INF;
        end
        if (ec == 2047) return c;
        if (az || bz) begin
            if (cz) return {sp & sc, 63'b0};
            return c;
        end
        p = 128'(ea != 0 ? ((a & F64_FRAC) | F64_HIDDEN) : (a & F64_FRAC)) *
            128'(eb != 0 ? ((b & F64_FRAC) | F64_HIDDEN) : (b & F64_FRAC));
        ep = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 2150;
        k = 125 - top_bit(p);
        p = p << k;
        ep -= k;
        if (cz) begin
            s = p; e = ep; sr = sp;
        end else begin
            q = 128'(ec != 0 ? ((c & F64_FRAC) | F64_HIDDEN) : (c & F64_FRAC));
            k = 125 - top_bit(q);
            q = q << k;
            ec = (ec != 0 ? ec : 1) - 1075 - k;
            if (ep >= ec) begin
                q = shr_sticky(q, ep - ec); e = ep;
            end else begin
                p = shr_sticky(p, ec - ep); e = ec;
            end
            if (sp == sc) begin
                s = p + q; sr = sp;
            end else if (p >= q) begin
                s = p - q; sr = sp;
            end else begin
                s = q - p; sr = sc;
            end
            if (s == 0) return 64'b0;
            k = 125 - top_bit(s);
            if (k > 0) s = s << k;
            else if (k < 0) s = shr_sticky(s, -k);
            e -= k;
        end
        biased = 125 + e + 1023;
        if (biased >= 2047) return {sr, 63'b0} | F64_INF;
        shift = 73;
        if (biased < 1) begin
            shift = 74 - biased;
            biased = 1;
        end
        t = shr_sticky(s, shift - 2);
        frac = {2'b0, t[63:2]};
        if (t[1] && (t[0] || frac[0])) frac++;
        r = (64'(biased - 1) << 52) + frac;
        if (r >= F64_INF) r = F64_INF;
        return {sr, 63'b0} | r;
    endfunction

    // -----------------------------------------------------------------------
    // Scoreboard: predicted C items, in order of arrival
    // -----------------------------------------------------------------------
    class matmul_scoreboard;
        logic [63:0] b_matrix [MAX_DEPTH*MAX_COLS];
        logic [63:0] acc [MAX_COLS];
        int          n_rows, n_inner, n_cols;
        t_out_item   c_due [$];
        int          errors;

        function new();
            foreach (b_matrix[i]) b_matrix[i] = '0;
            foreach (acc[i]) acc[i] = '0;
            n_rows = 1; n_inner = 1; n_cols = 1;
            errors = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ROW_COUNT:   n_rows  = int'(val[ROWCNT_W-1:0]);
                CFG_INNER_COUNT: n_inner = int'(val[INNER_W-1:0]);
                CFG_COL_COUNT:   n_cols  = int'(val[COLCNT_W-1:0]);
                default: ;
            endcase
        endfunction

        function int eff_cols();
            return n_cols > MAX_COLS ? MAX_COLS : n_cols;
        endfunction

        function int eff_inner();
            return n_inner > MAX_DEPTH ? MAX_DEPTH : n_inner;
        endfunction

        function void note_input(input t_in_item it);
            int cols, inner, rw, dp;
            t_out_item o;
            cols = eff_cols(); inner = eff_inner();
            rw = int'(it.row_index); dp = int'(it.depth_index);
            if (it.opcode == OP_LOAD_B) begin
                if (dp < inner && int'(it.col_index) < cols)
                    b_matrix[dp*MAX_COLS + int'(it.col_index)] = it.element_value;
                return;
            end
            if (rw >= n_rows || dp >= inner) return;
            if (dp == 0)
                foreach (acc[j]) acc[j] = '0;
            for (int j = 0; j < cols; j++)
                acc[j] = fused_mac(it.element_value, b_matrix[dp*MAX_COLS + j], acc[j]);
            if (dp + 1 != inner) return;
            for (int j = 0; j < cols; j++) begin
                o.out_row        = it.row_index;
                o.out_col        = COL_W'(j);
                o.out_value      = acc[j];
                o.last_of_row    = (j + 1 == cols);
                o.last_of_matrix = (j + 1 == cols) && (rw + 1 == n_rows);
                c_due.push_back(o);
            end
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (c_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected C item row %0d col %0d value %h",
                             got.out_row, got.out_col, got.out_value);
                return;
            end
            want = c_due.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: C item exp row %0d col %0d val %h lr %b lm %b / got row %0d col %0d val %h lr %b lm %b",
                             want.out_row, want.out_col, want.out_value, want.last_of_row,
                             want.last_of_matrix, got.out_row, got.out_col, got.out_value,
                             got.last_of_row, got.last_of_matrix);
            end
        endfunction

        function int pending();
            return c_due.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT hookup
    // -----------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    matmul_scoreboard sb = new();
    logic steady = 1'b0;    // when set, neither side idles
    int   n_counted = 0;    // in-range items sent by the random part

    fp64_matrix_multiply_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // C side: check accepted items, then pick the stall for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_item);
        i_out_stall <= !steady && ($urandom_range(99) < 18);
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    // operand mix: specials, subnormals, tame normals and raw bit patterns
    function automatic logic [63:0] pick_f64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(11))
            0: v = {v[63], 63'b0};                                  // signed zero
            1: v = {v[63], 11'h7FF, 52'b0};                         // infinity
            2: v = {v[63], 11'h7FF, v[51:1], 1'b1};                 // NaN
            3: v = {v[63], 11'h000, v[51:0]};                       // subnormal
            4: v = {v[63], 11'h7FE, v[51:0]};                       // near max
            5: v = {v[63], 11'h001, v[51:0]};                       // near min normal
            6, 7: ;                                                 // raw pattern
            default: v[62:52] = 11'(1023 - 20 + $urandom_range(40)); // tame
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        sb.set_reg(idx, CFG_DATA_W'(val));
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send(input t_in_item it);
        if (!steady && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic send_b(input int dp, input int cl, input logic [63:0] v);
        t_in_item it;
        it = {OP_LOAD_B, ROW_W'($urandom), DEPTH_W'(dp), COL_W'(cl), v};
        send(it);
    endtask

    task automatic send_a(input int rw, input int dp, input logic [63:0] v);
        t_in_item it;
        it = {OP_MAC, ROW_W'(rw), DEPTH_W'(dp), COL_W'($urandom), v};
        send(it);
    endtask

    // block idle: all C items in and the last sweep has had time to end
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_dims(input int rows, input int inner, input int cols);
        wait_idle();
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_INNER_COUNT, inner);
        write_reg(CFG_COL_COUNT, cols);
    endtask

    // one random matrix: full B, then A rows with some noise and stray items;
    // a calm matrix is a fixed 4x4 by 4x8 run with no idling on either side
    task automatic run_matrix(input logic calm);
        int rows, inner, cols;
        rows  = $urandom_range(1, 4);
        inner = $urandom_range(1, 4);
        cols  = ($urandom_range(5) == 0) ? 16 : $urandom_range(1, 4);
        if (calm) begin
            rows  = 4;
            inner = 4;
            cols  = 8;
        end
        set_dims(rows, inner, cols);
        steady = calm || ($urandom_range(4) == 0);
        for (int d = 0; d < inner; d++)
            for (int c = 0; c < cols; c++) begin
                send_b(d, c, pick_f64());
                n_counted++;
                if ($urandom_range(9) == 0)   // out-of-range load, dropped
                    send_b($urandom_range(inner, 511), $urandom_range(15), pick_f64());
            end
        for (int r = 0; r < rows; r++)
            for (int d = 0; d < inner; d++) begin
                case ($urandom_range(19))
                    0: send_a($urandom_range(rows, 1023), d, pick_f64()); // stray row
                    1: send_a($urandom_range(rows - 1), $urandom_range(inner - 1),
                              pick_f64());                              // broken order
                    default: ;
                endcase
                send_a(r, d, pick_f64());
                n_counted++;
            end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: inf*0, -0 sums, subnormal and overflow paths, stray items
        set_dims(2, 2, 2);
        send_b(0, 0, F64_INF);
        send_b(0, 1, F64_SIGN);
        send_b(1, 0, 64'h0000_0000_0000_0001);
        send_b(1, 1, 64'h7FEF_FFFF_FFFF_FFFF);
        send_b(2, 1, 64'h3FF0_0000_0000_0000);    // depth out of range
        send_b(0, 3, 64'h3FF0_0000_0000_0000);    // column out of range
        send_a(0, 0, 64'h0000_0000_0000_0000);
        send_a(0, 1, 64'h4000_0000_0000_0000);
        send_a(1, 0, F64_SIGN);
        send_a(1, 1, 64'hFFEF_FFFF_FFFF_FFFF);
        send_a(2, 0, 64'h3FF0_0000_0000_0000);    // row out of range
        send_a(0, 3, 64'h3FF0_0000_0000_0000);    // depth out of range
        send_a(1, 0, 64'h7FF8_0000_0000_0001);    // NaN operand
        send_a(1, 1, 64'h3CB0_0000_0000_0000);

        // largest dimensions; only depths 0 and 511 are touched
        set_dims(1024, 512, 16);
        for (int c = 0; c < 16; c++) begin
            send_b(0, c, pick_f64());
            send_b(511, c, pick_f64());
        end
        send_a(1023, 0, pick_f64());
        send_a(1023, 511, pick_f64());
        send_a(0, 0, pick_f64());
        send_a(0, 511, pick_f64());

        // inner and column counts past the limits are clamped
        set_dims(2047, 1023, 31);
        send_a(1023, 0, pick_f64());
        send_a(1023, 511, pick_f64());

        // zero inner dimension: every A item dropped
        set_dims(4, 0, 2);
        send_a(0, 0, pick_f64());
        send_a(1, 0, pick_f64());
        // zero columns: nothing accumulated, nothing emitted
        set_dims(4, 1, 0);
        send_a(0, 0, pick_f64());
        send_a(3, 0, pick_f64());

        // a long calm stretch, then random matrices; each one starts only
        // after the last has drained
        run_matrix(1'b1);
        run_matrix(1'b1);
        while (n_counted < 260)
            run_matrix(1'b0);
        steady = 1'b0;

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #30ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
